[rtl/efb_pkg.sv]
// ----------------------------------------------------------------------------
// efb_pkg
// shared types, sizes and codes of the event window frame builder
// ----------------------------------------------------------------------------
package efb_pkg;

   localparam int MAX_WIDTH   = 512;
   localparam int MAX_HEIGHT  = 512;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int X_W         = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int Y_W         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   localparam int CFG_W      = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int OPC_W      = 2;
   localparam int COORD_W    = 16;
   localparam int POL_W      = 8;
   localparam int TS_W       = 63;
   localparam int LEVEL_W    = 8;
   localparam int EPOCH_W    = 8;

   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int RSPQ_DEPTH = 2;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);

   localparam logic [CFG_W-1:0]     CFG_RESET        = CFG_W'(512);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);

   localparam logic [LEVEL_W-1:0] LEVEL_GRAY  = LEVEL_W'(127);
   localparam logic [LEVEL_W-1:0] LEVEL_BLACK = LEVEL_W'(0);
   localparam logic [LEVEL_W-1:0] LEVEL_WHITE = LEVEL_W'(255);

   typedef enum logic [OPC_W-1:0] {
      OPC_EVENT = 2'd0,
      OPC_OPEN  = 2'd1,
      OPC_READ  = 2'd2,
      OPC_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CODE_GRAY  = 2'd0,
      CODE_BLACK = 2'd1,
      CODE_WHITE = 2'd2
   } code_type;

   typedef enum logic [1:0] {
      CMD_PAINT = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type          op;
      logic [ADDR_W-1:0]   addr;
      code_type            code;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } cmdq_status_type;

   typedef struct packed {
      logic sweeping;
   } back_status_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      code_type           code;
   } entry_type;

endpackage

[rtl/efb_front.sv]
// ----------------------------------------------------------------------------
// efb_front
// holds the frame size and window registers, clamps coordinates and turns
// accepted beats into commands for the pixel store; none, out-of-window events
// and events with polarity above 1 give no command
module efb_front import efb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [OPC_W-1:0]     req_opcode,
   input  logic [COORD_W-1:0]   req_pixel_x,
   input  logic [COORD_W-1:0]   req_pixel_y,
   input  logic [POL_W-1:0]     req_polarity,
   input  logic [TS_W-1:0]      req_timestamp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output logic                 cmd_push,
   output cmd_type              cmd
);

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [TS_W-1:0]  start_ff, start_in;
   logic [TS_W-1:0]  end_ff, end_in;

   logic [CFG_W-1:0] w_lim, h_lim, x_max, y_max;
   logic [X_W-1:0]   x_c;
   logic [Y_W-1:0]   y_c;
   logic             in_win;

   always_comb begin
      w_lim = width_ff;
      if (width_ff == '0) begin
         w_lim = CFG_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_lim = CFG_W'(MAX_WIDTH);
      end
      h_lim = height_ff;
      if (height_ff == '0) begin
         h_lim = CFG_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_lim = CFG_W'(MAX_HEIGHT);
      end
      x_max = w_lim - CFG_W'(1);
      y_max = h_lim - CFG_W'(1);
      x_c = (req_pixel_x > COORD_W'(x_max)) ? X_W'(x_max) : X_W'(req_pixel_x);
      y_c = (req_pixel_y > COORD_W'(y_max)) ? Y_W'(y_max) : Y_W'(req_pixel_y);
      in_win = (req_timestamp >= start_ff) && (req_timestamp < end_ff);
   end

   always_comb begin
      cmd_push  = 1'b0;
      cmd.op    = CMD_READ;
      cmd.addr  = ADDR_W'(y_c) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_c);
      cmd.code  = (req_polarity == POL_W'(1)) ? CODE_BLACK : CODE_WHITE;
      start_in  = start_ff;
      end_in    = end_ff;
      case (opcode_type'(req_opcode))
         OPC_EVENT: begin
            cmd.op   = CMD_PAINT;
            cmd_push = accept && in_win && (req_polarity < POL_W'(2));
         end
         OPC_OPEN: begin
            cmd.op   = CMD_CLEAR;
            cmd_push = accept;
            if (accept) begin
               start_in = end_ff;
               end_in   = req_timestamp;
            end
         end
         OPC_READ: begin
            cmd.op   = CMD_READ;
            cmd_push = accept;
         end
         default: begin
            cmd_push = 1'b0;
         end
      endcase
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: height_in = csr_wdata;
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_RESET;
         height_ff <= CFG_RESET;
         start_ff  <= '0;
         end_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         start_ff  <= start_in;
         end_ff    <= end_in;
      end
   end

endmodule

[rtl/efb_cmd_queue.sv]
// ----------------------------------------------------------------------------
// efb_cmd_queue
// short command queue between the classifying front and the pixel store
// ----------------------------------------------------------------------------
module efb_cmd_queue import efb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  cmd_type         din,
   input  logic            pop,
   output cmd_type         dout,
   output cmdq_status_type status
);

   cmd_type                 slot_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_PTR_W:0]     count_ff, count_in;
   logic                    do_push, do_pop;

   always_comb begin
      status.full  = (count_ff == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = do_push ? wr_ptr_ff + CMDQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in    = do_pop  ? rd_ptr_ff + CMDQ_PTR_W'(1) : rd_ptr_ff;
      count_in     = count_ff + (CMDQ_PTR_W+1)'(do_push) - (CMDQ_PTR_W+1)'(do_pop);
      dout         = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/efb_back.sv]
// ----------------------------------------------------------------------------
// efb_back
// pixel store with epoch tags, clearing sweep, pixel reads and result queue
// ----------------------------------------------------------------------------
module efb_back import efb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  cmd_type             cmd,
   output logic                cmd_pop,
   output back_status_type     status,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output logic [LEVEL_W-1:0]  rsp_pixel_level
);

   typedef enum logic [1:0] {
      ST_SWEEP = 2'b01,
      ST_RUN   = 2'b10
   } back_state_type;

   back_state_type       state_ff, state_in;
   logic [ADDR_W-1:0]    sweep_addr_ff, sweep_addr_in;
   logic [EPOCH_W-1:0]   epoch_ff, epoch_in;
   logic                 rd_pend_ff;
   logic [EPOCH_W-1:0]   rd_epoch_ff;
   entry_type            rd_entry_ff;

   entry_type            store [STORE_DEPTH];
   logic                 mem_we, mem_re;
   logic [ADDR_W-1:0]    mem_addr;
   entry_type            mem_wdata;

   logic [LEVEL_W-1:0]   rspq_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0] rsp_wr_ff, rsp_rd_ff;
   logic [RSPQ_PTR_W:0]  rsp_count_ff, rsp_count_in;
   logic                 rsp_take, room;
   logic [LEVEL_W-1:0]   level;

   always_comb begin
      room     = (int'(rsp_count_ff) + int'(rd_pend_ff)) < RSPQ_DEPTH;
      cmd_pop  = (state_ff == ST_RUN) && cmd_valid && ((cmd.op != CMD_READ) || room);
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      mem_addr = cmd.addr;
      mem_wdata.epoch = epoch_ff;
      mem_wdata.code  = cmd.code;
      state_in      = state_ff;
      sweep_addr_in = sweep_addr_ff;
      epoch_in      = epoch_ff;
      case (state_ff)
         ST_SWEEP: begin
            mem_we          = 1'b1;
            mem_addr        = sweep_addr_ff;
            mem_wdata.epoch = '0;
            mem_wdata.code  = CODE_GRAY;
            sweep_addr_in   = sweep_addr_ff + ADDR_W'(1);
            if (sweep_addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cmd_pop) begin
               case (cmd.op)
                  CMD_PAINT: mem_we = 1'b1;
                  CMD_READ:  mem_re = 1'b1;
                  CMD_CLEAR: begin
                     epoch_in = epoch_ff + EPOCH_W'(1);
                     if (epoch_ff == '1) begin
                        state_in      = ST_SWEEP;
                        sweep_addr_in = '0;
                     end
                  end
                  default: begin
                     mem_we = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_SWEEP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_entry_ff <= store[mem_addr];
         rd_epoch_ff <= epoch_ff;
      end
   end

   // stale tag means the pixel was cleared by a later window
   always_comb begin
      level = LEVEL_GRAY;
      if (rd_entry_ff.epoch == rd_epoch_ff) begin
         case (rd_entry_ff.code)
            CODE_BLACK: level = LEVEL_BLACK;
            CODE_WHITE: level = LEVEL_WHITE;
            default:    level = LEVEL_GRAY;
         endcase
      end
   end

   always_comb begin
      rsp_empty       = (rsp_count_ff == '0);
      rsp_take        = rsp_pop && !rsp_empty;
      rsp_count_in    = rsp_count_ff + (RSPQ_PTR_W+1)'(rd_pend_ff)
                        - (RSPQ_PTR_W+1)'(rsp_take);
      rsp_pixel_level = rspq_ff[rsp_rd_ff];
      status.sweeping = (state_ff == ST_SWEEP);
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         rspq_ff[rsp_wr_ff] <= level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_addr_ff <= '0;
         epoch_ff      <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_wr_ff     <= '0;
         rsp_rd_ff     <= '0;
         rsp_count_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
         epoch_ff      <= epoch_in;
         rd_pend_ff    <= mem_re;
         rsp_wr_ff     <= rd_pend_ff ? rsp_wr_ff + RSPQ_PTR_W'(1) : rsp_wr_ff;
         rsp_rd_ff     <= rsp_take ? rsp_rd_ff + RSPQ_PTR_W'(1) : rsp_rd_ff;
         rsp_count_ff  <= rsp_count_in;
      end
   end

endmodule

[rtl/event_window_frame_builder.sv]
// ----------------------------------------------------------------------------
// event_window_frame_builder
// three-level frame built from camera events over a sliding time window
//
// channel   direction  handshake            payload
// req       in         req_push / req_full  opcode, pixel_x, pixel_y,
//                                           polarity, timestamp
// rsp       out        rsp_empty / rsp_pop  pixel_level
// csr       in         csr_we               csr_index, csr_wdata
//
// one beat per cycle sustained while req_full is low, set by the single port of the pixel store
// a read result passes the command queue, the store read register and the
// result queue before it shows on rsp; after reset req_full stays high while
// the store is swept, and every 256th open-window beat starts the same sweep
// a stalled rsp side fills the two-entry result queue, then the command
// queue, then raises req_full
// ----------------------------------------------------------------------------
module event_window_frame_builder import efb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [OPC_W-1:0]     req_opcode,
   input  logic [COORD_W-1:0]   req_pixel_x,
   input  logic [COORD_W-1:0]   req_pixel_y,
   input  logic [POL_W-1:0]     req_polarity,
   input  logic [TS_W-1:0]      req_timestamp,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [LEVEL_W-1:0]   rsp_pixel_level,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   logic            accept;
   logic            cmd_push, cmd_pop;
   cmd_type         cmd_in, cmd_out;
   cmdq_status_type q_status;
   back_status_type b_status;

   assign req_full = q_status.full || b_status.sweeping;
   assign accept   = req_push && !req_full;

   efb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_opcode    (req_opcode),
      .req_pixel_x   (req_pixel_x),
      .req_pixel_y   (req_pixel_y),
      .req_polarity  (req_polarity),
      .req_timestamp (req_timestamp),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmd_push      (cmd_push),
      .cmd           (cmd_in)
   );

   efb_cmd_queue u_cmd_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (cmd_push),
      .din    (cmd_in),
      .pop    (cmd_pop),
      .dout   (cmd_out),
      .status (q_status)
   );

   efb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (!q_status.empty),
      .cmd             (cmd_out),
      .cmd_pop         (cmd_pop),
      .status          (b_status),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pixel_level (rsp_pixel_level)
   );

endmodule

[rtl/efb_checker.sv]
// ----------------------------------------------------------------------------
// efb_checker
// port-level checks of the event window frame builder
// ----------------------------------------------------------------------------
module efb_checker import efb_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic [LEVEL_W-1:0] rsp_pixel_level
);

   // only the three grey levels ever leave the block
   a_level_legal: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_pixel_level == LEVEL_GRAY || rsp_pixel_level == LEVEL_BLACK
                      || rsp_pixel_level == LEVEL_WHITE))
      else $error("illegal pixel level");

   // store sweep blocks input right after reset
   a_sweep_after_reset: assert property (@(posedge clock)
      reset |=> req_full)
      else $error("input open during store sweep");

   // no result survives reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result present after reset");

   // a waiting result beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_pixel_level)))
      else $error("result beat changed while waiting");

endmodule

bind event_window_frame_builder efb_checker u_efb_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// regression of the event window frame builder: a directed table covering
// empty, backward and full-range windows, clamping and ignored beats, then
// random window sequences under several frame sizes, each read level checked
// against its table level or a behavioral frame model tracking the accepted req beats
// ----------------------------------------------------------------------------
module testbench;
   import efb_pkg::*;

   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASES       = 6;
   localparam int PHASE_BEATS  = 200;
   localparam int QUIET_BEATS  = 150;
   localparam int ROWS         = 35;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = CSR_IDX_W'(3);
   localparam logic [TS_W-1:0]      TS_MAX      = {TS_W{1'b1}};

   typedef enum logic { ROW_BEAT, ROW_CSR } row_kind_type;

   typedef struct packed {
      opcode_type          opc;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [POL_W-1:0]    pol;
      logic [TS_W-1:0]     ts;
   } req_beat_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [CFG_W-1:0]     wdata;
      opcode_type           opc;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic [POL_W-1:0]     pol;
      logic [TS_W-1:0]      ts;
      logic                 typed;
      logic [LEVEL_W-1:0]   level;
   } step_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [OPC_W-1:0]     req_opcode = '0;
   logic [COORD_W-1:0]   req_pixel_x = '0;
   logic [COORD_W-1:0]   req_pixel_y = '0;
   logic [POL_W-1:0]     req_polarity = '0;
   logic [TS_W-1:0]      req_timestamp = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [LEVEL_W-1:0]   rsp_pixel_level;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   // frame model: a pixel reads as painted only if its epoch matches the open window
   code_type             pix_code [STORE_DEPTH];
   int unsigned          pix_epoch [STORE_DEPTH];
   int unsigned          epoch_now = 1;
   logic [TS_W-1:0]      win_start = '0;
   logic [TS_W-1:0]      win_end = '0;
   logic [CFG_W-1:0]     cfg_width = CFG_RESET;
   logic [CFG_W-1:0]     cfg_height = CFG_RESET;

   logic [LEVEL_W-1:0]   pending_levels [$];
   int unsigned          mismatches = 0;
   int unsigned          cycles = 0;
   bit                   no_idle = 1'b0;
   bit                   stall_rsp_req = 1'b0;

   step_row_type         directed_rows [ROWS];
   logic [CFG_W-1:0]     phase_width [PHASES] = '{16, 1, 1023, 512, 0, 300};
   logic [CFG_W-1:0]     phase_height [PHASES] = '{8, 512, 1023, 1, 37, 0};

   event_window_frame_builder u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_polarity    (req_polarity),
      .req_timestamp   (req_timestamp),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pixel_level (rsp_pixel_level),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int unsigned active_size(input logic [CFG_W-1:0] value,
                                               input int unsigned maxv);
      if (value == 0) return 1;
      if (value > maxv) return maxv;
      return value;
   endfunction

   // returns 1 when the beat yields a level
   function automatic bit advance_frame(input req_beat_type b,
                                        output logic [LEVEL_W-1:0] level);
      int unsigned aw, ah, xc, yc, addr;
      aw = active_size(cfg_width, MAX_WIDTH);
      ah = active_size(cfg_height, MAX_HEIGHT);
      xc = (b.x > aw - 1) ? aw - 1 : b.x;
      yc = (b.y > ah - 1) ? ah - 1 : b.y;
      addr = yc * MAX_WIDTH + xc;
      level = LEVEL_GRAY;
      case (b.opc)
         OPC_EVENT: begin
            if (b.ts >= win_start && b.ts < win_end && b.pol <= 1) begin
               pix_epoch[addr] = epoch_now;
               pix_code[addr] = (b.pol == 1) ? CODE_BLACK : CODE_WHITE;
            end
            return 1'b0;
         end
         OPC_OPEN: begin
            win_start = win_end;
            win_end = b.ts;
            epoch_now++;
            return 1'b0;
         end
         OPC_READ: begin
            if (pix_epoch[addr] == epoch_now) begin
               if (pix_code[addr] == CODE_BLACK) level = LEVEL_BLACK;
               else if (pix_code[addr] == CODE_WHITE) level = LEVEL_WHITE;
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] random_coord(input int unsigned limit);
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return COORD_W'($urandom_range(0, 65535));
      if (pick == 1) return COORD_W'(limit - 1 + $urandom_range(0, 2));
      return COORD_W'($urandom_range(0, ((limit < 8) ? limit : 8) - 1));
   endfunction

   // mostly in-window events on a few pixels, reads of the same pixels
   function automatic req_beat_type random_beat();
      req_beat_type    b;
      int unsigned     pick;
      logic [63:0]     r;
      logic [TS_W-1:0] span;
      pick = $urandom_range(0, 99);
      r = {$urandom, $urandom};
      if (pick < 3) b.opc = OPC_OPEN;
      else if (pick < 52) b.opc = OPC_EVENT;
      else if (pick < 97) b.opc = OPC_READ;
      else b.opc = OPC_NONE;
      b.x = random_coord(active_size(cfg_width, MAX_WIDTH));
      b.y = random_coord(active_size(cfg_height, MAX_HEIGHT));
      if ($urandom_range(0, 6) != 0) b.pol = POL_W'($urandom_range(0, 1));
      else b.pol = POL_W'($urandom_range(0, 255));
      span = win_end - win_start;
      pick = $urandom_range(0, 19);
      if (b.opc == OPC_OPEN) begin
         if (pick == 0) b.ts = r[TS_W-1:0];
         else if (pick == 1) b.ts = TS_MAX;
         else b.ts = win_end + TS_W'($urandom_range(1, 100000));
      end else begin
         if (win_end > win_start && pick < 16) b.ts = win_start + r[TS_W-1:0] % span;
         else if (pick < 18) b.ts = win_end;
         else b.ts = r[TS_W-1:0];
      end
      return b;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("mismatch at cycle %0d: %s", cycles, what);
   endtask

   task automatic push_beat(input req_beat_type b, input logic typed,
                            input logic [LEVEL_W-1:0] typed_level);
      logic [LEVEL_W-1:0] level;
      req_push <= 1'b1;
      req_opcode <= b.opc;
      req_pixel_x <= b.x;
      req_pixel_y <= b.y;
      req_polarity <= b.pol;
      req_timestamp <= b.ts;
      do @(posedge clock); while (req_full !== 1'b0);
      if (advance_frame(b, level)) begin
         pending_levels.insert(pending_levels.size(), typed ? typed_level : level);
      end
      if (!no_idle && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CFG_W-1:0] value);
      req_push <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_FRAME_WIDTH) cfg_width = value;
      else if (idx == CSR_FRAME_HEIGHT) cfg_height = value;
      csr_we <= 1'b0;
   endtask

   // rsp side: pop stretches, short stalls, one long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if (stall_rsp_req) begin
            stall_rsp_req = 1'b0;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      logic [LEVEL_W-1:0] want;
      if (!reset && rsp_pop && rsp_empty === 1'b0) begin
         if (pending_levels.size() == 0) begin
            report_mismatch($sformatf("unexpected rsp beat, level %0d", rsp_pixel_level));
         end else begin
            want = pending_levels.pop_front();
            if (rsp_pixel_level !== want)
               report_mismatch($sformatf("pixel_level %0d, expected %0d",
                                         rsp_pixel_level, want));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("event_window_frame_builder regression: fail");
         $finish;
      end
   end

   initial begin
      req_beat_type b;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      directed_rows = '{
         '{ROW_BEAT, '0, '0, OPC_READ,  16'd0,     16'd0,     8'd0,   63'd0,      1'b1, LEVEL_GRAY},
         '{ROW_BEAT, '0, '0, OPC_READ,  16'hffff,  16'hffff,  8'd0,   63'd0,      1'b1, LEVEL_GRAY},
         '{ROW_BEAT, '0, '0, OPC_EVENT, 16'd5,     16'd5,     8'd1,   63'd0,      1'b0, '0},
         '{ROW_BEAT, '0, '0, OPC_READ,  16'd5,     16'd5,     8'd0,   63'd0,      1'b1, LEVEL_GRAY},
         '{ROW_BEAT, '0, '0, OPC_OPEN,  16'd0,     16'd0,     8'd0,   63'd1000,   1'b0, '0},
         '{ROW_BEAT, '0, '0, OPC_EVENT, 16'd5,     16'd5,     8'd1,   63'd0,      1'b0, '0},
         '{ROW_BEAT, '0, '0, OPC_READ,  16'd5,     16'd5,     8'd0,   63'd0,      1'b1, LEVEL_BLACK},
         '{ROW_BEAT, '0, '0, OPC_EVENT, 16'hffff,  16'hffff,  8'd0,   63'd999,    1'b0, '0},
         '{ROW_BEAT, '0, '0, OPC_READ,  16'd511,   16'd511,   8'd0,   63'd0,      1'b1, LEVEL_WHITE},
         '{ROW_BEAT, '0, '0, OPC_EVENT, 16'd7,     16'd7,     8'd2,   63'd10,     1'b0, '0},
         '{ROW_BEAT, '0, '0, OPC_EVENT, 16'd8,     16'd8,     8'd255, 63'd10,     1'b0, '0},
         '{ROW_BEAT, '0, '0, OPC_READ,  16'd7,     16'd7,     8'd0,   63'd0,      1'b0, '0},
         '{ROW_BEAT, '0, '0, OPC_READ,  16'd8,     16'd8,     8'd0,   63'd0,      1'b0, '0},
         '{ROW_BEAT, '0, '0, OPC_EVENT, 16'd9,     16'd9,     8'd1,   63'd1000,   1'b0, '0},
         '{ROW_BEAT, '0, '0, OPC_READ,  16'd9,     16'd9,     8'd0,   63'd0,      1'b1, LEVEL_GRAY},
         '{ROW_BEAT, '0, '0, OPC_NONE,  16'hffff,  16'hffff,  8'hff,  TS_MAX,     1'b0, '0},
         '{ROW_BEAT, '0, '0, OPC_OPEN,  16'd0,     16'd0,     8'd0,   63'd500,    1'b0, '0},
         '{ROW_BEAT, '0, '0, OPC_READ,  16'd511,   16'd511,   8'd0,   63'd0,      1'b1, LEVEL_GRAY},
         '{ROW_BEAT, '0, '0, OPC_EVENT, 16'd5,     16'd5,     8'd1,   63'd700,    1'b0, '0},
         '{ROW_BEAT, '0, '0, OPC_READ,  16'd5,     16'd5,     8'd0,   63'd0,      1'b0, '0},
         '{ROW_BEAT, '0, '0, OPC_OPEN,  16'd0,     16'd0,     8'd0,   TS_MAX,     1'b0, '0},
         '{ROW_BEAT, '0, '0, OPC_EVENT, 16'd0,     16'd0,     8'd1,   TS_MAX - 1, 1'b0, '0},
         '{ROW_BEAT, '0, '0, OPC_EVENT, 16'd1,     16'd0,     8'd0,   TS_MAX,     1'b0, '0},
         '{ROW_BEAT, '0, '0, OPC_READ,  16'd0,     16'd0,     8'd0,   63'd0,      1'b1, LEVEL_BLACK},
         '{ROW_BEAT, '0, '0, OPC_READ,  16'd1,     16'd0,     8'd0,   63'd0,      1'b0, '0},
         '{ROW_CSR,  CSR_FRAME_WIDTH,  10'd0, OPC_NONE, '0, '0, '0, '0, 1'b0, '0},
         '{ROW_CSR,  CSR_FRAME_HEIGHT, 10'd0, OPC_NONE, '0, '0, '0, '0, 1'b0, '0},
         '{ROW_CSR,  CSR_SPARE_2,      10'd3, OPC_NONE, '0, '0, '0, '0, 1'b0, '0},
         '{ROW_CSR,  CSR_SPARE_3,      10'd3, OPC_NONE, '0, '0, '0, '0, 1'b0, '0},
         '{ROW_BEAT, '0, '0, OPC_EVENT, 16'd300,   16'd400,   8'd0,   63'd600,    1'b0, '0},
         '{ROW_BEAT, '0, '0, OPC_READ,  16'd2,     16'd0,     8'd0,   63'd0,      1'b1, LEVEL_WHITE},
         '{ROW_CSR,  CSR_FRAME_WIDTH,  10'd1023, OPC_NONE, '0, '0, '0, '0, 1'b0, '0},
         '{ROW_CSR,  CSR_FRAME_HEIGHT, 10'd1023, OPC_NONE, '0, '0, '0, '0, 1'b0, '0},
         '{ROW_BEAT, '0, '0, OPC_READ,  16'd511,   16'd511,   8'd0,   63'd0,      1'b1, LEVEL_GRAY},
         '{ROW_BEAT, '0, '0, OPC_READ,  16'd0,     16'd0,     8'd0,   63'd0,      1'b1, LEVEL_WHITE}
      };
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            write_register(directed_rows[i].idx, directed_rows[i].wdata);
         end else begin
            b = '{directed_rows[i].opc, directed_rows[i].x, directed_rows[i].y,
                  directed_rows[i].pol, directed_rows[i].ts};
            push_beat(b, directed_rows[i].typed, directed_rows[i].level);
         end
      end
      for (int p = 0; p < PHASES; p++) begin
         write_register(CSR_FRAME_WIDTH, phase_width[p]);
         write_register(CSR_FRAME_HEIGHT, phase_height[p]);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (p == 1 && n == 50) stall_rsp_req = 1'b1;
            if (p == PHASES - 1 && n == PHASE_BEATS - QUIET_BEATS) no_idle = 1'b1;
            push_beat(random_beat(), 1'b0, LEVEL_GRAY);
         end
      end
      req_push <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_levels.size() == 0) begin
         $display("event_window_frame_builder regression: pass");
      end else begin
         $display("event_window_frame_builder regression: fail");
      end
      $finish;
   end

endmodule
